### rtl/ogr_pkg.sv
// Shared constants, types and helper functions for the occupancy grid ray update block.
// Every other file in the block imports this package. It has no dependencies.
package ogr_pkg;

   // Grid geometry. Grid coordinates wrap modulo GRID_SIDE.
   localparam int GRID_SIDE = 256;
   localparam int COORD_W   = $clog2(GRID_SIDE);
   localparam int ADDR_W    = 2 * COORD_W;

   // Fixed field widths of the channels.
   localparam int IN_W       = 8;
   localparam int SENSOR_W   = 2;
   localparam int CELL_W     = 8;
   localparam int COUNT_W    = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // An input coordinate is reduced modulo GRID_SIDE in a register of this width.
   localparam int RED_W = (COORD_W > IN_W) ? COORD_W : IN_W;
   // Bresenham error term, which stays within twice the largest coordinate span.
   localparam int ERR_W = IN_W + 3;

   localparam int NB_COUNT  = 9;
   localparam int NB_W      = $clog2(NB_COUNT);
   localparam logic [NB_W-1:0] NB_LAST   = NB_W'(NB_COUNT - 1);
   localparam logic [NB_W-1:0] NB_CENTER = NB_W'(4);

   localparam logic [CELL_W-1:0] CELL_MAX = {CELL_W{1'b1}};

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ULTRASONIC_GAIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LASER_GAIN      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAR_STEP      = 2'd2;

   localparam logic [CSR_DATA_W-1:0] ULTRASONIC_GAIN_RST = 8'd32;
   localparam logic [CSR_DATA_W-1:0] LASER_GAIN_RST      = 8'd64;
   localparam logic [CSR_DATA_W-1:0] CLEAR_STEP_RST      = 8'd8;

   // Sensor kinds; any other code adds nothing.
   localparam logic [SENSOR_W-1:0] SENSOR_ULTRASONIC = 2'd0;
   localparam logic [SENSOR_W-1:0] SENSOR_LASER      = 2'd1;

   // Unit offsets along one axis.
   localparam logic [1:0] OFS_NONE = 2'd0;
   localparam logic [1:0] OFS_INC  = 2'd1;
   localparam logic [1:0] OFS_DEC  = 2'd2;

   typedef struct packed {
      logic sweep_step;
      logic load_item;
      logic wrap_step;
      logic walk_step;
      logic nb_step;
      logic load_rsp;
   } ogr_cmd_type;

   typedef struct packed {
      logic sweep_done;
      logic wrap_done;
      logic at_target;
      logic nb_last;
   } ogr_status_type;

   // Moves a grid coordinate by one step, wrapping at both edges.
   function automatic logic [COORD_W-1:0] wrap_offset(input logic [COORD_W-1:0] c,
                                                      input logic [1:0] ofs);
      logic [COORD_W-1:0] r;
      r = c;
      case (ofs)
         OFS_INC: r = (c == COORD_W'(GRID_SIDE - 1)) ? '0 : c + COORD_W'(1);
         OFS_DEC: r = (c == '0) ? COORD_W'(GRID_SIDE - 1) : c - COORD_W'(1);
         default: r = c;
      endcase
      return r;
   endfunction

   // Neighbour x offsets: -1, 1, 0, 0, 0, -1, -1, 1, 1.
   function automatic logic [1:0] nb_dx(input logic [NB_W-1:0] k);
      logic [1:0] r;
      case (k)
         NB_W'(0), NB_W'(5), NB_W'(6): r = OFS_DEC;
         NB_W'(1), NB_W'(7), NB_W'(8): r = OFS_INC;
         default:                      r = OFS_NONE;
      endcase
      return r;
   endfunction

   // Neighbour y offsets: 0, 0, 1, -1, 0, 1, -1, 1, -1.
   function automatic logic [1:0] nb_dy(input logic [NB_W-1:0] k);
      logic [1:0] r;
      case (k)
         NB_W'(2), NB_W'(5), NB_W'(7): r = OFS_INC;
         NB_W'(3), NB_W'(6), NB_W'(8): r = OFS_DEC;
         default:                      r = OFS_NONE;
      endcase
      return r;
   endfunction

endpackage

### rtl/ogr_req_if.sv
// Range hit channel: valid/ready handshake with the hit's coordinates and sensor kind.
// Depends on ogr_pkg for the field widths.
interface ogr_req_if;
   import ogr_pkg::*;
   logic                valid;
   logic                ready;
   logic [IN_W-1:0]     origin_x;
   logic [IN_W-1:0]     origin_y;
   logic [IN_W-1:0]     target_x;
   logic [IN_W-1:0]     target_y;
   logic [SENSOR_W-1:0] sensor;

   modport source(output valid, origin_x, origin_y, target_x, target_y, sensor,
                  input ready);
   modport sink(input valid, origin_x, origin_y, target_x, target_y, sensor,
                output ready);
endinterface

### rtl/ogr_rsp_if.sv
// Result channel: valid/ready handshake with the cleared cell count and target level.
// Depends on ogr_pkg for the field widths.
interface ogr_rsp_if;
   import ogr_pkg::*;
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] cleared_count;
   logic [CELL_W-1:0]  target_level;

   modport source(output valid, cleared_count, target_level, input ready);
   modport sink(input valid, cleared_count, target_level, output ready);
endinterface

### rtl/ogr_csr_if.sv
// Configuration write channel: valid/ready handshake with a register index and write data.
// Depends on ogr_pkg for the field widths.
interface ogr_csr_if;
   import ogr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

### rtl/ogr_ctrl.sv
// Controller for the occupancy grid ray update: sequences clearing, wrap, ray walk,
// neighbour update and result hand-off. Depends on ogr_pkg.
module ogr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  ogr_pkg::ogr_status_type status,
   output ogr_pkg::ogr_cmd_type    cmd,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready
);
   import ogr_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_WRAP  = 3'd2;
   localparam logic [2:0] ST_WALK  = 3'd3;
   localparam logic [2:0] ST_NEIGH = 3'd4;
   localparam logic [2:0] ST_FIN   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.sweep_step = !status.sweep_done;
            if (status.sweep_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_WRAP;
            end
         end
         ST_WRAP: begin
            cmd.wrap_step = 1'b1;
            if (status.wrap_done) state_in = ST_WALK;
         end
         ST_WALK: begin
            // The cell that holds the target is never cleared.
            if (status.at_target) state_in = ST_NEIGH;
            else cmd.walk_step = 1'b1;
         end
         ST_NEIGH: begin
            cmd.nb_step = 1'b1;
            if (status.nb_last) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/ogr_dpath.sv
// Datapath for the occupancy grid ray update: grid memory, configuration registers,
// Bresenham stepper, neighbour addressing and read-modify-write pipe. Depends on ogr_pkg.
module ogr_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  ogr_pkg::ogr_cmd_type               cmd,
   output ogr_pkg::ogr_status_type            status,
   input  logic [ogr_pkg::IN_W-1:0]           origin_x,
   input  logic [ogr_pkg::IN_W-1:0]           origin_y,
   input  logic [ogr_pkg::IN_W-1:0]           target_x,
   input  logic [ogr_pkg::IN_W-1:0]           target_y,
   input  logic [ogr_pkg::SENSOR_W-1:0]       sensor,
   input  logic                               csr_write,
   input  logic [ogr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ogr_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic [ogr_pkg::COUNT_W-1:0]        cleared_count,
   output logic [ogr_pkg::CELL_W-1:0]         target_level
);
   import ogr_pkg::*;

   // Reduces a coordinate by GRID_SIDE once if it is not yet below it.
   function automatic logic [RED_W-1:0] reduce_once(input logic [RED_W-1:0] v);
      logic [RED_W:0] wide;
      wide = {1'b0, v};
      if (wide >= (RED_W+1)'(GRID_SIDE)) return RED_W'(wide - (RED_W+1)'(GRID_SIDE));
      else return v;
   endfunction

   function automatic logic below_side(input logic [RED_W-1:0] v);
      return {1'b0, v} < (RED_W+1)'(GRID_SIDE);
   endfunction

   // Configuration registers.
   logic [CELL_W-1:0] ugain_ff, lgain_ff, cstep_ff;

   // Clearing pass after reset.
   logic [ADDR_W-1:0] sweep_addr_ff;
   logic              sweep_done_ff;

   // Ray walk state: unwrapped coordinates drive the stepper, wrapped ones the address.
   logic [IN_W-1:0]         x_ff, y_ff, tx_ff, ty_ff, dx_ff;
   logic signed [IN_W:0]    dy_ff;
   logic signed [ERR_W-1:0] err_ff;
   logic                    sx_neg_ff, sy_neg_ff;
   logic [RED_W-1:0]        wx_ff, wy_ff, twx_ff, twy_ff;
   logic [SENSOR_W-1:0]     sensor_ff;
   logic [COUNT_W-1:0]      count_ff;
   logic [NB_W-1:0]         nb_ff;
   logic [CELL_W-1:0]       level_ff;

   // Read-modify-write pipe: a read is issued, and the cell is written in the following cycle.
   logic              pend_valid_ff, pend_raise_ff, pend_target_ff;
   logic [ADDR_W-1:0] pend_addr_ff;
   logic              byp_ff;
   logic [CELL_W-1:0] byp_data_ff, rd_data_ff;

   logic [COUNT_W-1:0] rsp_count_ff;
   logic [CELL_W-1:0]  rsp_level_ff;

   logic [CELL_W-1:0] grid_mem [2**ADDR_W];

   // Item load.
   logic [IN_W-1:0]         dx_new, dy_mag;
   logic signed [IN_W:0]    dy_new;
   logic signed [ERR_W-1:0] err_new;

   assign dx_new  = (target_x > origin_x) ? target_x - origin_x : origin_x - target_x;
   assign dy_mag  = (target_y > origin_y) ? target_y - origin_y : origin_y - target_y;
   assign dy_new  = -$signed({1'b0, dy_mag});
   assign err_new = ERR_W'($signed({1'b0, dx_new})) + ERR_W'(dy_new);

   // Bresenham step.
   logic signed [ERR_W:0]   e2;
   logic                    step_x, step_y;
   logic signed [ERR_W-1:0] err_step;
   logic [COORD_W-1:0]      wx_step, wy_step;

   assign e2      = {err_ff, 1'b0};
   assign step_x  = e2 >= (ERR_W+1)'(dy_ff);
   assign step_y  = e2 <= (ERR_W+1)'($signed({1'b0, dx_ff}));
   assign err_step = err_ff + (step_x ? ERR_W'(dy_ff) : '0)
                            + (step_y ? ERR_W'($signed({1'b0, dx_ff})) : '0);
   assign wx_step = wrap_offset(wx_ff[COORD_W-1:0],
                                step_x ? (sx_neg_ff ? OFS_DEC : OFS_INC) : OFS_NONE);
   assign wy_step = wrap_offset(wy_ff[COORD_W-1:0],
                                step_y ? (sy_neg_ff ? OFS_DEC : OFS_INC) : OFS_NONE);

   // Read address: current ray cell or current neighbour.
   logic [ADDR_W-1:0] walk_addr, nb_addr, rd_addr;
   logic              issue;

   assign walk_addr = {wy_ff[COORD_W-1:0], wx_ff[COORD_W-1:0]};
   assign nb_addr   = {wrap_offset(twy_ff[COORD_W-1:0], nb_dy(nb_ff)),
                       wrap_offset(twx_ff[COORD_W-1:0], nb_dx(nb_ff))};
   assign rd_addr   = cmd.nb_step ? nb_addr : walk_addr;
   assign issue     = cmd.walk_step | cmd.nb_step;

   // Cell update.
   logic [CELL_W-1:0] gain, old_cell, new_cell, mem_wd;
   logic [CELL_W:0]   sum;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa;

   always_comb begin
      case (sensor_ff)
         SENSOR_ULTRASONIC: gain = ugain_ff;
         SENSOR_LASER:      gain = lgain_ff;
         default:           gain = '0;
      endcase
   end

   // A read that hits the cell being written this cycle takes the new value.
   assign old_cell = byp_ff ? byp_data_ff : rd_data_ff;
   assign sum      = {1'b0, old_cell} + {1'b0, gain};
   assign new_cell = pend_raise_ff ? (sum[CELL_W] ? CELL_MAX : sum[CELL_W-1:0])
                                   : ((old_cell < cstep_ff) ? '0 : old_cell - cstep_ff);
   assign mem_we   = cmd.sweep_step | pend_valid_ff;
   assign mem_wa   = cmd.sweep_step ? sweep_addr_ff : pend_addr_ff;
   assign mem_wd   = cmd.sweep_step ? '0 : new_cell;

   always_ff @(posedge clock) begin
      if (mem_we) grid_mem[mem_wa] <= mem_wd;
      rd_data_ff <= grid_mem[rd_addr];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         ugain_ff      <= ULTRASONIC_GAIN_RST;
         lgain_ff      <= LASER_GAIN_RST;
         cstep_ff      <= CLEAR_STEP_RST;
         sweep_addr_ff <= '0;
         sweep_done_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_ULTRASONIC_GAIN: ugain_ff <= csr_data;
               CSR_LASER_GAIN:      lgain_ff <= csr_data;
               CSR_CLEAR_STEP:      cstep_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.sweep_step) begin
            sweep_addr_ff <= sweep_addr_ff + ADDR_W'(1);
            if (sweep_addr_ff == {ADDR_W{1'b1}}) sweep_done_ff <= 1'b1;
         end
         pend_valid_ff <= issue;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         x_ff      <= origin_x;
         y_ff      <= origin_y;
         tx_ff     <= target_x;
         ty_ff     <= target_y;
         dx_ff     <= dx_new;
         dy_ff     <= dy_new;
         err_ff    <= err_new;
         sx_neg_ff <= !(origin_x < target_x);
         sy_neg_ff <= !(origin_y < target_y);
         wx_ff     <= RED_W'(origin_x);
         wy_ff     <= RED_W'(origin_y);
         twx_ff    <= RED_W'(target_x);
         twy_ff    <= RED_W'(target_y);
         sensor_ff <= sensor;
         count_ff  <= '0;
         nb_ff     <= '0;
      end
      if (cmd.wrap_step) begin
         wx_ff  <= reduce_once(wx_ff);
         wy_ff  <= reduce_once(wy_ff);
         twx_ff <= reduce_once(twx_ff);
         twy_ff <= reduce_once(twy_ff);
      end
      if (cmd.walk_step) begin
         if (step_x) x_ff <= sx_neg_ff ? x_ff - IN_W'(1) : x_ff + IN_W'(1);
         if (step_y) y_ff <= sy_neg_ff ? y_ff - IN_W'(1) : y_ff + IN_W'(1);
         wx_ff    <= RED_W'(wx_step);
         wy_ff    <= RED_W'(wy_step);
         err_ff   <= err_step;
         count_ff <= count_ff + COUNT_W'(1);
      end
      if (cmd.nb_step) nb_ff <= nb_ff + NB_W'(1);
      if (issue) begin
         pend_raise_ff  <= cmd.nb_step;
         pend_target_ff <= cmd.nb_step && (nb_ff == NB_CENTER);
         pend_addr_ff   <= rd_addr;
         byp_ff         <= pend_valid_ff && (pend_addr_ff == rd_addr);
         byp_data_ff    <= new_cell;
      end
      if (pend_valid_ff && pend_target_ff) level_ff <= new_cell;
      if (cmd.load_rsp) begin
         rsp_count_ff <= count_ff;
         rsp_level_ff <= level_ff;
      end
   end

   assign status.sweep_done = sweep_done_ff;
   assign status.wrap_done  = below_side(wx_ff) && below_side(wy_ff)
                              && below_side(twx_ff) && below_side(twy_ff);
   assign status.at_target  = (x_ff == tx_ff) && (y_ff == ty_ff);
   assign status.nb_last    = (nb_ff == NB_LAST);

   assign cleared_count = rsp_count_ff;
   assign target_level  = rsp_level_ff;

endmodule

### rtl/occupancy_grid_ray_update.sv
// Top level of the occupancy grid ray update block: channel ports, controller and datapath.
// Depends on ogr_pkg, the three channel interfaces, ogr_ctrl and ogr_dpath.
//
// Usage. Each transfer on req_ch is one range hit: origin, target and sensor kind. The
// block walks the Bresenham line from the origin toward the target, lowering each
// crossed cell by clear_step (floor 0), then raises the target and its eight neighbours
// by the sensor's gain (ceiling 255). Each hit gives exactly one transfer on rsp_ch with
// the number of cells cleared and the target's new level. csr_ch writes the gain and
// clear step registers at any time the block is idle; it is always ready.
// Sequence. An accepted hit has its coordinates wrapped; then the ray is walked from the
// origin toward the target, the nine neighbour cells are updated in turn, the result is
// loaded into the result register, and the next hit can be taken. The grid memory does
// one read and one write per cycle, so the walk and the neighbour updates handle one cell
// at a time. One item is processed at a time. The wrap subtracts GRID_SIDE repeatedly until
// all coordinates are below it; with GRID_SIDE of 256 or more they already are.
// Reset. After reset all 2^(2*clog2(GRID_SIDE)) grid cells (65536 for a 256 grid) are
// cleared, one cell per cycle; req_ch.ready stays low meanwhile.
// Stalls. The result sits in an output register; the next hit is accepted and processed
// while it waits, and that hit's result is held back until rsp_ch takes the first.
module occupancy_grid_ray_update (
   input logic   clock,
   input logic   reset,
   ogr_req_if.sink   req_ch,
   ogr_rsp_if.source rsp_ch,
   ogr_csr_if.sink   csr_ch
);
   import ogr_pkg::*;

   ogr_cmd_type    cmd;
   ogr_status_type status;

   assign csr_ch.ready = 1'b1;

   ogr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .cmd       (cmd),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready)
   );

   ogr_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .origin_x      (req_ch.origin_x),
      .origin_y      (req_ch.origin_y),
      .target_x      (req_ch.target_x),
      .target_y      (req_ch.target_y),
      .sensor        (req_ch.sensor),
      .csr_write     (csr_ch.valid),
      .csr_index     (csr_ch.index),
      .csr_data      (csr_ch.data),
      .cleared_count (rsp_ch.cleared_count),
      .target_level  (rsp_ch.target_level)
   );

   // No hit is taken before the grid clearing pass has finished.
   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |-> status.sweep_done)
      else $error("hit accepted before grid clear finished");

   // The walk never clears the target cell.
   a_walk_stops_at_target: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> !status.at_target)
      else $error("ray walk stepped on the target cell");

   // A loaded result is presented in the next cycle.
   a_result_presented: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_ch.valid)
      else $error("loaded result not presented");

   // Only one phase of an item is active in a cycle.
   a_one_phase: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.sweep_step, cmd.load_item, cmd.wrap_step, cmd.walk_step, cmd.nb_step}))
      else $error("more than one processing phase active");

endmodule

### tb/tb_occupancy_grid_ray_update.sv
// Self-checking testbench for occupancy_grid_ray_update: a directed table of range hits,
// then random hits in phases with different register settings and random idling.
// Depends on ogr_pkg and the ogr_req_if, ogr_rsp_if and ogr_csr_if interfaces.
module tb_occupancy_grid_ray_update;
   import ogr_pkg::*;

   localparam logic [SENSOR_W-1:0] SENSOR_NONE     = 2'd2;
   localparam logic [SENSOR_W-1:0] SENSOR_RESERVED = 2'd3;
   localparam int DIRECTED_ROWS    = 22;
   localparam int PHASE_COUNT      = 6;
   localparam int HITS_PER_PHASE   = 305;
   localparam int RSP_HOLD_CYCLES  = 600;
   localparam int DRAIN_LIMIT      = 20000;
   localparam int SETTLE_CYCLES    = 300;

   typedef struct packed {
      logic [IN_W-1:0]     origin_x;
      logic [IN_W-1:0]     origin_y;
      logic [IN_W-1:0]     target_x;
      logic [IN_W-1:0]     target_y;
      logic [SENSOR_W-1:0] sensor;
   } range_hit_type;

   typedef struct packed {
      logic [COUNT_W-1:0] cleared_count;
      logic [CELL_W-1:0]  target_level;
   } hit_result_type;

   typedef struct packed {
      logic [IN_W-1:0]     origin_x;
      logic [IN_W-1:0]     origin_y;
      logic [IN_W-1:0]     target_x;
      logic [IN_W-1:0]     target_y;
      logic [SENSOR_W-1:0] sensor;
      logic                typed;
      logic [COUNT_W-1:0]  cleared_count;
      logic [CELL_W-1:0]   target_level;
   } hit_row_type;

   logic clock;
   logic reset;

   ogr_req_if req_ch();
   ogr_rsp_if rsp_ch();
   ogr_csr_if csr_ch();

   occupancy_grid_ray_update i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Predicted grid contents and register copies.
   logic [CELL_W-1:0]     occ_level [GRID_SIDE*GRID_SIDE];
   logic [CSR_DATA_W-1:0] gain_ultrasonic;
   logic [CSR_DATA_W-1:0] gain_laser;
   logic [CSR_DATA_W-1:0] ray_clear_step;

   int nb_x_ofs [0:NB_COUNT-1] = '{-1, 1, 0, 0, 0, -1, -1, 1, 1};
   int nb_y_ofs [0:NB_COUNT-1] = '{0, 0, 1, -1, 0, 1, -1, 1, -1};

   hit_result_type awaited_ray_results [$];
   int          error_count;
   bit          no_idle;
   bit          rsp_hold_req;
   logic [IN_W-1:0] hot_x;
   logic [IN_W-1:0] hot_y;

   // Typed results hold only for the first rows after reset with the reset register values.
   hit_row_type directed_hits [DIRECTED_ROWS] = '{
      '{8'd0,   8'd0,   8'd0,   8'd0,   SENSOR_ULTRASONIC, 1'b1, 8'd0,   8'd32},
      '{8'd128, 8'd128, 8'd128, 8'd128, SENSOR_LASER,      1'b1, 8'd0,   8'd64},
      '{8'd64,  8'd64,  8'd64,  8'd64,  SENSOR_NONE,       1'b1, 8'd0,   8'd0},
      '{8'd100, 8'd100, 8'd100, 8'd100, SENSOR_RESERVED,   1'b1, 8'd0,   8'd0},
      '{8'd0,   8'd50,  8'd255, 8'd50,  SENSOR_LASER,      1'b1, 8'd255, 8'd64},
      '{8'd200, 8'd0,   8'd200, 8'd255, SENSOR_ULTRASONIC, 1'b1, 8'd255, 8'd32},
      '{8'd255, 8'd255, 8'd0,   8'd0,   SENSOR_LASER,      1'b0, 8'd0,   8'd0},
      '{8'd10,  8'd10,  8'd20,  8'd15,  SENSOR_ULTRASONIC, 1'b0, 8'd0,   8'd0},
      '{8'd20,  8'd15,  8'd10,  8'd10,  SENSOR_LASER,      1'b0, 8'd0,   8'd0},
      '{8'd30,  8'd30,  8'd33,  8'd60,  SENSOR_ULTRASONIC, 1'b0, 8'd0,   8'd0},
      '{8'd33,  8'd60,  8'd30,  8'd30,  SENSOR_LASER,      1'b0, 8'd0,   8'd0},
      '{8'd250, 8'd5,   8'd3,   8'd250, SENSOR_LASER,      1'b0, 8'd0,   8'd0},
      '{8'd120, 8'd120, 8'd128, 8'd128, SENSOR_LASER,      1'b0, 8'd0,   8'd0},
      '{8'd120, 8'd120, 8'd128, 8'd128, SENSOR_LASER,      1'b0, 8'd0,   8'd0},
      '{8'd120, 8'd120, 8'd128, 8'd128, SENSOR_LASER,      1'b0, 8'd0,   8'd0},
      '{8'd120, 8'd120, 8'd128, 8'd128, SENSOR_LASER,      1'b0, 8'd0,   8'd0},
      '{8'd120, 8'd120, 8'd136, 8'd136, SENSOR_ULTRASONIC, 1'b0, 8'd0,   8'd0},
      '{8'd0,   8'd255, 8'd0,   8'd255, SENSOR_ULTRASONIC, 1'b0, 8'd0,   8'd0},
      '{8'd255, 8'd0,   8'd255, 8'd0,   SENSOR_LASER,      1'b0, 8'd0,   8'd0},
      '{8'd1,   8'd2,   8'd254, 8'd253, SENSOR_NONE,       1'b0, 8'd0,   8'd0},
      '{8'd77,  8'd33,  8'd78,  8'd200, SENSOR_RESERVED,   1'b0, 8'd0,   8'd0},
      '{8'd255, 8'd128, 8'd0,   8'd127, SENSOR_LASER,      1'b0, 8'd0,   8'd0}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40000000;
      $display("FAIL");
      $finish;
   end

   function automatic int grid_index(input int x, input int y);
      int wx;
      int wy;
      wx = ((x % GRID_SIDE) + GRID_SIDE) % GRID_SIDE;
      wy = ((y % GRID_SIDE) + GRID_SIDE) % GRID_SIDE;
      return wy * GRID_SIDE + wx;
   endfunction

   // Walks the ray on unwrapped coordinates, lowering each crossed cell, then raises the
   // target and its eight neighbours. Updates the predicted grid in place.
   function automatic hit_result_type predict_ray_update(input range_hit_type h);
      int x0, y0, x1, y1;
      int dx, dy, sx, sy, err, e2;
      int steps, gain, a, s, k;
      hit_result_type r;
      x0 = h.origin_x;
      y0 = h.origin_y;
      x1 = h.target_x;
      y1 = h.target_y;
      steps = 0;
      if (h.sensor == SENSOR_ULTRASONIC) gain = gain_ultrasonic;
      else if (h.sensor == SENSOR_LASER) gain = gain_laser;
      else gain = 0;
      dx = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy = (y1 > y0) ? y0 - y1 : y1 - y0;
      sx = (x0 < x1) ? 1 : -1;
      sy = (y0 < y1) ? 1 : -1;
      err = dx + dy;
      while (!(x0 == x1 && y0 == y1)) begin
         a = grid_index(x0, y0);
         occ_level[a] = (occ_level[a] < ray_clear_step) ? '0 : occ_level[a] - ray_clear_step;
         steps++;
         e2 = 2 * err;
         if (e2 >= dy) begin
            err += dy;
            x0 += sx;
         end
         if (e2 <= dx) begin
            err += dx;
            y0 += sy;
         end
      end
      for (k = 0; k < NB_COUNT; k++) begin
         a = grid_index(x1 + nb_x_ofs[k], y1 + nb_y_ofs[k]);
         s = int'(occ_level[a]) + gain;
         occ_level[a] = (s > int'(CELL_MAX)) ? CELL_MAX : CELL_W'(s);
      end
      r.cleared_count = COUNT_W'(steps);
      r.target_level  = occ_level[grid_index(x1, y1)];
      return r;
   endfunction

   function automatic logic [SENSOR_W-1:0] random_sensor();
      int pick;
      pick = $urandom_range(99);
      if (pick < 45) return SENSOR_ULTRASONIC;
      else if (pick < 90) return SENSOR_LASER;
      else if (pick < 95) return SENSOR_NONE;
      else return SENSOR_RESERVED;
   endfunction

   function automatic logic [IN_W-1:0] pick_hot_coord();
      case ($urandom_range(3))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'd128;
         default: return IN_W'($urandom_range(255));
      endcase
   endfunction

   // Most hits land near a hotspot so cells build up and drain again; the rest are spread
   // over the whole grid. Offsets wrap in eight bits, so hotspots near an edge give long rays.
   function automatic range_hit_type random_range_hit();
      range_hit_type h;
      int kind;
      kind = $urandom_range(99);
      h.sensor = random_sensor();
      if (kind < 55) begin
         h.origin_x = hot_x + IN_W'($urandom_range(15)) - 8'd8;
         h.origin_y = hot_y + IN_W'($urandom_range(15)) - 8'd8;
         h.target_x = h.origin_x + IN_W'($urandom_range(24)) - 8'd12;
         h.target_y = h.origin_y + IN_W'($urandom_range(24)) - 8'd12;
      end else if (kind < 75) begin
         h.origin_x = IN_W'($urandom_range(255));
         h.origin_y = IN_W'($urandom_range(255));
         h.target_x = IN_W'($urandom_range(255));
         h.target_y = IN_W'($urandom_range(255));
         h.sensor   = SENSOR_W'($urandom_range(3));
      end else if (kind < 85) begin
         h.origin_x = IN_W'($urandom_range(255));
         h.origin_y = IN_W'($urandom_range(255));
         h.target_x = h.origin_x;
         h.target_y = h.origin_y;
      end else if (kind < 95) begin
         h.origin_x = IN_W'($urandom_range(255));
         h.origin_y = IN_W'($urandom_range(255));
         h.target_x = $urandom_range(1) ? h.origin_x : IN_W'($urandom_range(255));
         h.target_y = (h.target_x == h.origin_x) ? IN_W'($urandom_range(255)) : h.origin_y;
      end else begin
         // Repeated hits on one target push it into saturation.
         h.target_x = hot_x + IN_W'($urandom_range(2)) - 8'd1;
         h.target_y = hot_y + IN_W'($urandom_range(2)) - 8'd1;
         h.origin_x = h.target_x + IN_W'($urandom_range(6)) - 8'd3;
         h.origin_y = h.target_y + IN_W'($urandom_range(6)) - 8'd3;
         h.sensor   = SENSOR_LASER;
      end
      return h;
   endfunction

   task automatic offer_hit(input range_hit_type h, input logic typed,
                            input hit_result_type res);
      hit_result_type predicted;
      while (!no_idle && $urandom_range(99) < 21) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.origin_x <= h.origin_x;
      req_ch.origin_y <= h.origin_y;
      req_ch.target_x <= h.target_x;
      req_ch.target_y <= h.target_y;
      req_ch.sensor   <= h.sensor;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = predict_ray_update(h);
      awaited_ray_results.push_back(typed ? res : predicted);
   endtask

   // Leaves valid high; the caller drops it after the last write of a group.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         CSR_ULTRASONIC_GAIN: gain_ultrasonic = value;
         CSR_LASER_GAIN:      gain_laser = value;
         CSR_CLEAR_STEP:      ray_clear_step = value;
         default: ;
      endcase
   endtask

   // Every hit gives a result, so an empty queue means the block is idle.
   task automatic wait_block_idle();
      req_ch.valid <= 1'b0;
      while (awaited_ray_results.size() != 0) @(posedge clock);
   endtask

   task automatic check_ray_result();
      hit_result_type want;
      if (awaited_ray_results.size() == 0) begin
         $display("%0t: unexpected result cleared_count=%0d target_level=%0d", $time,
                  rsp_ch.cleared_count, rsp_ch.target_level);
         error_count++;
      end else begin
         want = awaited_ray_results.pop_front();
         if (rsp_ch.cleared_count !== want.cleared_count) begin
            $display("%0t: cleared_count expected %0d actual %0d", $time,
                     want.cleared_count, rsp_ch.cleared_count);
            error_count++;
         end
         if (rsp_ch.target_level !== want.target_level) begin
            $display("%0t: target_level expected %0d actual %0d", $time,
                     want.target_level, rsp_ch.target_level);
            error_count++;
         end
      end
   endtask

   // Result side: random back-pressure, and one long hold-off on request from the sender.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) check_ray_result();
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end
         rsp_ch.ready <= no_idle || ($urandom_range(99) >= 21);
      end
   end

   initial begin
      hit_row_type    row;
      range_hit_type  h;
      hit_result_type res;
      int          guard;
      error_count     = 0;
      no_idle         = 1'b0;
      rsp_hold_req    = 1'b0;
      hot_x           = '0;
      hot_y           = '0;
      gain_ultrasonic = ULTRASONIC_GAIN_RST;
      gain_laser      = LASER_GAIN_RST;
      ray_clear_step  = CLEAR_STEP_RST;
      foreach (occ_level[i]) occ_level[i] = '0;
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.origin_x <= '0;
      req_ch.origin_y <= '0;
      req_ch.target_x <= '0;
      req_ch.target_y <= '0;
      req_ch.sensor   <= '0;
      csr_ch.valid    <= 1'b0;
      csr_ch.index    <= '0;
      csr_ch.data     <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // The block clears its grid after reset; the first transfer simply waits for ready.
      foreach (directed_hits[i]) begin
         row = directed_hits[i];
         h   = '{row.origin_x, row.origin_y, row.target_x, row.target_y, row.sensor};
         res = '{row.cleared_count, row.target_level};
         offer_hit(h, row.typed, res);
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_block_idle();
         case (p)
            0: begin
               write_reg(CSR_ULTRASONIC_GAIN, 8'd0);
               write_reg(CSR_LASER_GAIN, 8'd0);
               write_reg(CSR_CLEAR_STEP, 8'd0);
            end
            1: begin
               write_reg(CSR_ULTRASONIC_GAIN, 8'd255);
               write_reg(CSR_LASER_GAIN, 8'd255);
               write_reg(CSR_CLEAR_STEP, 8'd255);
            end
            2: begin
               write_reg(CSR_ULTRASONIC_GAIN, 8'd255);
               write_reg(CSR_LASER_GAIN, 8'd1);
               write_reg(CSR_CLEAR_STEP, 8'd0);
            end
            5: begin
               write_reg(CSR_ULTRASONIC_GAIN, CSR_DATA_W'($urandom_range(255)));
               write_reg(CSR_LASER_GAIN, CSR_DATA_W'($urandom_range(255)));
               write_reg(CSR_CLEAR_STEP, CSR_DATA_W'($urandom_range(1, 16)));
            end
            default: begin
               write_reg(CSR_CLEAR_STEP, CSR_DATA_W'($urandom_range(255)));
               write_reg(CSR_LASER_GAIN, CSR_DATA_W'($urandom_range(255)));
               write_reg(CSR_ULTRASONIC_GAIN, CSR_DATA_W'($urandom_range(255)));
            end
         endcase
         csr_ch.valid <= 1'b0;
         no_idle = (p == 2);
         if (p == 3) rsp_hold_req = 1'b1;
         hot_x = pick_hot_coord();
         hot_y = pick_hot_coord();
         for (int n = 0; n < HITS_PER_PHASE; n++) begin
            if (n % 100 == 99) begin
               hot_x = pick_hot_coord();
               hot_y = pick_hot_coord();
            end
            offer_hit(random_range_hit(), 1'b0, '0);
         end
      end

      req_ch.valid <= 1'b0;
      guard = 0;
      while (awaited_ray_results.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      if (awaited_ray_results.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time,
                  awaited_ray_results.size());
         error_count++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### sim.f
rtl/ogr_pkg.sv
rtl/ogr_req_if.sv
rtl/ogr_rsp_if.sv
rtl/ogr_csr_if.sv
rtl/ogr_ctrl.sv
rtl/ogr_dpath.sv
rtl/occupancy_grid_ray_update.sv
tb/tb_occupancy_grid_ray_update.sv
